// ----- hdl/ptts_pkg.sv -----
// Shared constants, codes and slot table types of the periodic task scheduler.
package ptts_pkg;

	localparam int SLOTS = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
	localparam logic [7:0] AGE_MAX = 8'hFF;

	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_ADD      = 3'd1,
		ACT_REMOVE   = 3'd2,
		ACT_DISPATCH = 3'd3,
		ACT_SET_TIME = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	// Contents of the addressed slot as seen by the sequencer.
	typedef struct packed {
		logic        used;
		logic        pend;
		logic [7:0]  id;
		logic [31:0] param;
		logic [15:0] period;
		logic [15:0] cnt;
		logic [7:0]  age;
	} slot_t;

	// Write command to the slot that the table index addresses.
	typedef struct packed {
		logic              wr_used;
		logic              used;
		logic              wr_pend;
		logic              pend;
		logic              wr_cnt;
		logic [15:0]       cnt;
		logic              wr_age;
		logic [7:0]        age;
		logic              wr_data;
		logic [7:0]        id;
		logic [31:0]       param;
		logic [15:0]       period;
	} slot_wr_t;

endpackage

// ----- hdl/ptts_table.sv -----
// Slot table of the periodic task scheduler: one shared read and write port.
module ptts_table import ptts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] idx,
	input  slot_wr_t          wr,
	output slot_t             rd
);

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] pend_q;
	logic [7:0]       id_q     [SLOTS];
	logic [31:0]      param_q  [SLOTS];
	logic [15:0]      period_q [SLOTS];
	logic [15:0]      cnt_q    [SLOTS];
	logic [7:0]       age_q    [SLOTS];

	// Only the in-use and pending marks need a known value after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			pend_q <= '0;
		end else begin
			if (wr.wr_used) begin
				used_q[idx] <= wr.used;
			end
			if (wr.wr_pend) begin
				pend_q[idx] <= wr.pend;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.wr_cnt) begin
			cnt_q[idx] <= wr.cnt;
		end
		if (wr.wr_age) begin
			age_q[idx] <= wr.age;
		end
		if (wr.wr_data) begin
			id_q[idx]     <= wr.id;
			param_q[idx]  <= wr.param;
			period_q[idx] <= wr.period;
		end
	end

	always_comb begin
		rd.used   = used_q[idx];
		rd.pend   = pend_q[idx];
		rd.id     = id_q[idx];
		rd.param  = param_q[idx];
		rd.period = period_q[idx];
		rd.cnt    = cnt_q[idx];
		rd.age    = age_q[idx];
	end

endmodule

// ----- hdl/periodic_task_table_scheduler.sv -----
// Top level of the periodic task scheduler: command sequencer over the slot table.
//
// Channel   Handshake            Word
// --------  -------------------  ---------------------------------------------------
// command   start high, busy low  action, task_id, task_param, task_period,
//                                 first_delay, time_value
// result    done, one cycle       status, out_task_id, out_param, current_time
//
// Every command gives exactly one result word. Set time and unknown actions answer in
// the cycle after acceptance and never raise busy. A tick walks all SLOTS slots. Add,
// remove and dispatch first scan all SLOTS slots and then decide; a duplicate id, a
// full table, a missing id or no pending task is answered from that decision. Else add
// ages the table and writes the new entry, remove and a dispatch of a run-once task
// free the slot with a second pass over all SLOTS slots, and a periodic dispatch
// clears its pending mark. The passes come from the single read and write port of
// the slot table, which the sequencer visits one slot per cycle. Reset empties the table
// and clears the time at once. The receiver cannot stall, so done is a plain strobe.
module periodic_task_table_scheduler import ptts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [7:0]  task_id,
	input  logic [31:0] task_param,
	input  logic [15:0] task_period,
	input  logic [15:0] first_delay,
	input  logic [31:0] time_value,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  out_task_id,
	output logic [31:0] out_param,
	output logic [31:0] current_time
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_SCAN,
		S_DECIDE,
		S_AGE,
		S_FREE,
		S_FIN_ADD,
		S_CLR_PEND
	} state_t;

	state_t            state_q;
	action_t           act_q;
	status_t           status_q;
	logic              done_q;
	logic [31:0]       time_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [SLOT_W-1:0] k_q;
	logic [7:0]        age_k_q;
	logic              found_q;
	logic              dup_q;
	logic              zero_per_q;
	logic [7:0]        tid_q;
	logic [31:0]       param_q;
	logic [15:0]       period_q;
	logic [15:0]       delay_q;
	logic [7:0]        oid_q;
	logic [31:0]       oparam_q;

	logic [SLOT_W-1:0] slot_idx;
	slot_wr_t          wr;
	slot_t             rd;

	logic last_slot;

	assign last_slot = (ptr_q == LAST_SLOT);

	ptts_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (slot_idx),
		.wr     (wr),
		.rd     (rd)
	);

	// During the passes the walk pointer addresses the table; the closing writes of
	// add and dispatch go to the slot found by the scan.
	always_comb begin
		case (state_q)
			S_FIN_ADD, S_CLR_PEND: begin
				slot_idx = k_q;
			end
			default: begin
				slot_idx = ptr_q;
			end
		endcase
	end

	// The one slot update of this cycle.
	always_comb begin
		wr = '0;
		case (state_q)
			S_TICK: begin
				if (rd.used) begin
					wr.wr_cnt = 1'b1;
					if (rd.cnt == 16'd0) begin
						wr.wr_pend = 1'b1;
						wr.pend    = 1'b1;
						wr.cnt     = rd.period;
					end else begin
						wr.cnt = rd.cnt - 16'd1;
					end
				end
			end
			S_AGE: begin
				// The new entry becomes rank zero, so every older one below AGE_MAX moves back.
				if (rd.used && rd.age != AGE_MAX) begin
					wr.wr_age = 1'b1;
					wr.age    = rd.age + 8'd1;
				end
			end
			S_FREE: begin
				// Free the chosen slot and close the gap in the ranks behind it.
				if (ptr_q == k_q) begin
					wr.wr_used = 1'b1;
					wr.used    = 1'b0;
					wr.wr_pend = 1'b1;
					wr.pend    = 1'b0;
				end else if (rd.used && rd.age > age_k_q) begin
					wr.wr_age = 1'b1;
					wr.age    = rd.age - 8'd1;
				end
			end
			S_FIN_ADD: begin
				wr.wr_used = 1'b1;
				wr.used    = 1'b1;
				wr.wr_pend = 1'b1;
				wr.pend    = 1'b0;
				wr.wr_cnt  = 1'b1;
				wr.cnt     = delay_q;
				wr.wr_age  = 1'b1;
				wr.age     = 8'd0;
				wr.wr_data = 1'b1;
				wr.id      = tid_q;
				wr.param   = param_q;
				wr.period  = period_q;
			end
			S_CLR_PEND: begin
				wr.wr_pend = 1'b1;
				wr.pend    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, scan results and the registered result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			act_q      <= ACT_TICK;
			status_q   <= ST_OK;
			done_q     <= 1'b0;
			time_q     <= '0;
			ptr_q      <= '0;
			k_q        <= '0;
			age_k_q    <= '0;
			found_q    <= 1'b0;
			dup_q      <= 1'b0;
			zero_per_q <= 1'b0;
			tid_q      <= '0;
			param_q    <= '0;
			period_q   <= '0;
			delay_q    <= '0;
			oid_q      <= '0;
			oparam_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q      <= action_t'(action);
						tid_q      <= task_id;
						param_q    <= task_param;
						period_q   <= task_period;
						delay_q    <= first_delay;
						ptr_q      <= '0;
						found_q    <= 1'b0;
						dup_q      <= 1'b0;
						zero_per_q <= 1'b0;
						oid_q      <= '0;
						oparam_q   <= '0;
						status_q   <= ST_OK;
						case (action_t'(action))
							ACT_TICK: begin
								time_q  <= time_q + 32'd1;
								state_q <= S_TICK;
							end
							ACT_ADD, ACT_REMOVE, ACT_DISPATCH: begin
								state_q <= S_SCAN;
							end
							ACT_SET_TIME: begin
								time_q <= time_value;
								done_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_TICK: begin
					ptr_q <= ptr_q + SLOT_W'(1);
					if (last_slot) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					case (act_q)
						ACT_ADD: begin
							if (rd.used && rd.id == tid_q) begin
								dup_q <= 1'b1;
							end
							if (!rd.used && !found_q) begin
								found_q <= 1'b1;
								k_q     <= ptr_q;
							end
						end
						ACT_REMOVE: begin
							if (rd.used && rd.id == tid_q && !found_q) begin
								found_q <= 1'b1;
								k_q     <= ptr_q;
								age_k_q <= rd.age;
							end
						end
						ACT_DISPATCH: begin
							// Keep the youngest pending task; the first one wins a tie.
							if (rd.used && rd.pend && (!found_q || rd.age < age_k_q)) begin
								found_q    <= 1'b1;
								k_q        <= ptr_q;
								age_k_q    <= rd.age;
								oid_q      <= rd.id;
								oparam_q   <= rd.param;
								zero_per_q <= (rd.period == 16'd0);
							end
						end
						default: begin
						end
					endcase
					ptr_q <= ptr_q + SLOT_W'(1);
					if (last_slot) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					ptr_q <= '0;
					case (act_q)
						ACT_ADD: begin
							if (dup_q) begin
								status_q <= ST_DUP;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (!found_q) begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_AGE;
							end
						end
						ACT_REMOVE: begin
							if (!found_q) begin
								status_q <= ST_NOTFOUND;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_FREE;
							end
						end
						ACT_DISPATCH: begin
							if (!found_q) begin
								status_q <= ST_NONE;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (zero_per_q) begin
								state_q <= S_FREE;
							end else begin
								state_q <= S_CLR_PEND;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_AGE: begin
					ptr_q <= ptr_q + SLOT_W'(1);
					if (last_slot) begin
						state_q <= S_FIN_ADD;
					end
				end
				S_FREE: begin
					ptr_q <= ptr_q + SLOT_W'(1);
					if (last_slot) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FIN_ADD, S_CLR_PEND: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign out_task_id  = oid_q;
	assign out_param    = oparam_q;
	assign current_time = time_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench of the periodic task table scheduler.
//
// A scoreboard object keeps its own copy of the slot table and the system time.
// Every command word that the block accepts is applied to that copy, and the
// answer it yields waits in a queue until the block strobes done. Each result word
// is then checked field by field against the oldest waiting answer.
//
// The stimulus starts with a short directed run:
//   - dispatch and remove on an empty table;
//   - the time wrapping past its top value;
//   - adds with extreme field values and a duplicate id;
//   - a slot whose countdown is found at zero while it is already pending;
//   - newest-first dispatch, and a run-once task freed by its dispatch;
//   - the unused action codes.
// The random run follows. It draws ids from a small pool so that duplicates,
// hits on remove and a full table all happen often. Short periods and delays keep
// tasks turning pending, and occasional bursts of adds fill the table.
module testbench;
	import ptts_pkg::*;

	// Action codes above set time are unused; the block must answer them with ok.
	localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;

	localparam int RANDOM_WORDS = 1500;
	localparam int ID_POOL      = 24;
	localparam int BURST_ADDS   = 18;
	// Long enough for the longest command and its done strobe.
	localparam int DRAIN_CYCLES = 2 * SLOTS + 4;
	// Cycles with neither an accepted command nor a result before the run is
	// given up. The slowest command plus the longest sender gap is well below this.
	localparam int IDLE_LIMIT   = 2000;

	typedef struct {
		logic [2:0]  action;
		logic [7:0]  id;
		logic [31:0] param;
		logic [15:0] period;
		logic [15:0] delay;
		logic [31:0] tval;
	} command_t;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  id;
		logic [31:0] param;
		logic [31:0] now;
	} answer_t;

	// Holds a copy of the slot table and the answers still owed by the block.
	class schedule_scoreboard;
		bit        used[SLOTS];
		bit        pend[SLOTS];
		bit [7:0]  tag[SLOTS];
		bit [31:0] word[SLOTS];
		bit [15:0] reload[SLOTS];
		bit [15:0] count[SLOTS];
		bit [7:0]  rank[SLOTS];
		bit [31:0] clock_now;
		answer_t   awaited[$];
		int        failures;

		function int find_task(logic [7:0] tid);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && tag[i] == tid)
					return i;
			return -1;
		endfunction

		// Frees a slot; every older entry (larger rank) moves up one place.
		function void release_slot(int k);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && rank[i] > rank[k])
					rank[i]--;
			used[k] = 1'b0;
			pend[k] = 1'b0;
		endfunction

		function void note_command(command_t c);
			answer_t a;
			int      k;
			a.status = ST_OK;
			a.id = '0;
			a.param = '0;
			k = -1;
			case (c.action)
				ACT_TICK: begin
					clock_now++;
					for (int i = 0; i < SLOTS; i++) begin
						if (used[i]) begin
							if (count[i] == 0) begin
								pend[i] = 1'b1;
								count[i] = reload[i];
							end else begin
								count[i]--;
							end
						end
					end
				end
				ACT_ADD: begin
					if (find_task(c.id) >= 0) begin
						a.status = ST_DUP;
					end else begin
						for (int i = SLOTS - 1; i >= 0; i--)
							if (!used[i])
								k = i;
						if (k < 0) begin
							a.status = ST_FULL;
						end else begin
							for (int i = 0; i < SLOTS; i++)
								if (used[i] && rank[i] != AGE_MAX)
									rank[i]++;
							used[k] = 1'b1;
							pend[k] = 1'b0;
							tag[k] = c.id;
							word[k] = c.param;
							reload[k] = c.period;
							count[k] = c.delay;
							rank[k] = '0;
						end
					end
				end
				ACT_REMOVE: begin
					k = find_task(c.id);
					if (k < 0)
						a.status = ST_NOTFOUND;
					else
						release_slot(k);
				end
				ACT_DISPATCH: begin
					for (int i = 0; i < SLOTS; i++)
						if (used[i] && pend[i] && (k < 0 || rank[i] < rank[k]))
							k = i;
					if (k < 0) begin
						a.status = ST_NONE;
					end else begin
						a.id = tag[k];
						a.param = word[k];
						pend[k] = 1'b0;
						if (reload[k] == 0)
							release_slot(k);
					end
				end
				ACT_SET_TIME: begin
					clock_now = c.tval;
				end
				default: begin
				end
			endcase
			a.now = clock_now;
			awaited.push_back(a);
		endfunction

		function void check_answer(answer_t got);
			answer_t want;
			if (awaited.size() == 0) begin
				$error("result word with no command outstanding");
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.id !== want.id) begin
				$error("out_task_id: expected %0d, actual %0d", want.id, got.id);
				failures++;
			end
			if (got.param !== want.param) begin
				$error("out_param: expected %h, actual %h", want.param, got.param);
				failures++;
			end
			if (got.now !== want.now) begin
				$error("current_time: expected %h, actual %h", want.now, got.now);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  action;
	logic [7:0]  task_id;
	logic [31:0] task_param;
	logic [15:0] task_period;
	logic [15:0] first_delay;
	logic [31:0] time_value;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  out_task_id;
	logic [31:0] out_param;
	logic [31:0] current_time;

	schedule_scoreboard board = new();

	periodic_task_table_scheduler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.task_id      (task_id),
		.task_param   (task_param),
		.task_period  (task_period),
		.first_delay  (first_delay),
		.time_value   (time_value),
		.done         (done),
		.status       (status),
		.out_task_id  (out_task_id),
		.out_param    (out_param),
		.current_time (current_time)
	);

	always #5 clk = ~clk;

	// The receiver never stalls, so every done strobe is a result word to check.
	always @(posedge clk) begin : result_monitor
		answer_t seen;
		if (done === 1'b1) begin
			seen.status = status;
			seen.id = out_task_id;
			seen.param = out_param;
			seen.now = current_time;
			board.check_answer(seen);
		end
	end

	// Presents one command word and holds it until the block takes it. With a gap,
	// start drops and the payload ports carry junk that the block must ignore.
	// Called at a rising edge; returns at a rising edge.
	task automatic issue(command_t c, int gap);
		action <= c.action;
		task_id <= c.id;
		task_param <= c.param;
		task_period <= c.period;
		first_delay <= c.delay;
		time_value <= c.tval;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		board.note_command(c);
		if (gap > 0) begin
			start <= 1'b0;
			action <= 3'($urandom);
			task_id <= 8'($urandom);
			task_param <= $urandom;
			task_period <= 16'($urandom);
			first_delay <= 16'($urandom);
			time_value <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic command_t make_cmd(logic [2:0] act, logic [7:0] tid,
			logic [31:0] prm, logic [15:0] per, logic [15:0] dly, logic [31:0] tv);
		command_t c;
		c.action = act;
		c.id = tid;
		c.param = prm;
		c.period = per;
		c.delay = dly;
		c.tval = tv;
		return c;
	endfunction

	initial begin : stimulus
		command_t   c;
		logic [7:0] id_pool[ID_POOL];
		int         burst_left;
		int         pick;
		int         r;
		int         gap;
		bit         quiet;

		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_TICK;
		task_id <= '0;
		task_param <= '0;
		task_period <= '0;
		first_delay <= '0;
		time_value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table: nothing to dispatch and nothing to remove.
		issue(make_cmd(ACT_DISPATCH, 8'h00, '0, '0, '0, '0), $urandom_range(0, 2));
		issue(make_cmd(ACT_REMOVE, 8'h05, '0, '0, '0, '0), $urandom_range(0, 2));
		issue(make_cmd(ACT_TICK, '0, '0, '0, '0, '0), $urandom_range(0, 2));
		// Time wraps from its top value back to zero.
		issue(make_cmd(ACT_SET_TIME, '0, '0, '0, '0, 32'hFFFF_FFFF), $urandom_range(0, 2));
		issue(make_cmd(ACT_TICK, '0, '0, '0, '0, '0), $urandom_range(0, 2));
		// Extreme adds, then a duplicate of the first id.
		issue(make_cmd(ACT_ADD, 8'h00, 32'h0, 16'h0, 16'h0, '0), $urandom_range(0, 2));
		issue(make_cmd(ACT_ADD, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, '0), 0);
		issue(make_cmd(ACT_ADD, 8'h00, 32'hA5A5_5A5A, 16'h3, 16'h1, '0), 0);
		issue(make_cmd(ACT_ADD, 8'h07, 32'h1234_5678, 16'h2, 16'h1, '0), $urandom_range(0, 2));
		// The second tick finds the run-once task at zero while it is still pending.
		issue(make_cmd(ACT_TICK, '0, '0, '0, '0, '0), 0);
		issue(make_cmd(ACT_TICK, '0, '0, '0, '0, '0), $urandom_range(0, 2));
		// Newest pending goes first; the run-once task leaves the table on dispatch.
		issue(make_cmd(ACT_DISPATCH, '0, '0, '0, '0, '0), 0);
		issue(make_cmd(ACT_DISPATCH, '0, '0, '0, '0, '0), 0);
		issue(make_cmd(ACT_DISPATCH, '0, '0, '0, '0, '0), $urandom_range(0, 2));
		// Unused action codes change nothing, whatever the payload says.
		issue(make_cmd(ACT_FIRST_UNUSED, 8'h07, $urandom, 16'h0, 16'h0, $urandom), 0);
		issue(make_cmd(ACT_LAST_UNUSED, 8'hFF, $urandom, 16'hFFFF, 16'hFFFF, $urandom), 0);
		issue(make_cmd(ACT_REMOVE, 8'hFF, '0, '0, '0, '0), 0);
		issue(make_cmd(ACT_REMOVE, 8'hFF, '0, '0, '0, '0), $urandom_range(0, 2));
		issue(make_cmd(ACT_SET_TIME, '0, '0, '0, '0, 32'h0), 0);

		// A small id pool keeps duplicates and remove hits frequent; the pool is
		// larger than the table, so adds also run into a full table.
		id_pool[0] = 8'h00;
		id_pool[1] = 8'hFF;
		for (int i = 2; i < ID_POOL; i++)
			id_pool[i] = 8'($urandom);
		burst_left = 0;
		quiet = 1'b0;

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// Some stretches of a hundred words run back to back with no gaps.
			if (n % 100 == 0)
				quiet = ($urandom_range(0, 9) < 3);
			if (burst_left == 0 && $urandom_range(0, 99) < 2)
				burst_left = BURST_ADDS;

			c.id = ($urandom_range(0, 99) < 4) ? 8'($urandom)
				: id_pool[$urandom_range(0, ID_POOL - 1)];
			c.param = $urandom;
			r = $urandom_range(0, 9);
			c.period = (r < 7) ? 16'($urandom_range(0, 6))
				: (r < 9) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			r = $urandom_range(0, 9);
			c.delay = (r < 7) ? 16'($urandom_range(0, 6))
				: (r < 9) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			// Times just below the top value make the following ticks wrap.
			c.tval = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8)
				: $urandom;

			pick = $urandom_range(0, 99);
			if (burst_left > 0) begin
				c.action = ACT_ADD;
				burst_left--;
			end else if (pick < 35) begin
				c.action = ACT_TICK;
			end else if (pick < 60) begin
				c.action = ACT_ADD;
			end else if (pick < 75) begin
				c.action = ACT_REMOVE;
			end else if (pick < 93) begin
				c.action = ACT_DISPATCH;
			end else if (pick < 97) begin
				c.action = ACT_SET_TIME;
			end else begin
				c.action = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
			end

			// Mostly short gaps, now and then a long one.
			r = $urandom_range(0, 99);
			gap = quiet ? 0 : (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 3)
				: (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 60);
			issue(c, gap);
		end
		start <= 1'b0;

		// Every command answers once, so an empty queue means the block is idle.
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.awaited.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Ends a run that has stopped moving: no command taken and no result seen.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 || arst_n !== 1'b1)
				idle = 0;
			else
				idle++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
